FILE: design/sliding_window_rate_meter_core_macros.svh
// assertion macros for the sliding window rate meter
`ifndef SLIDING_WINDOW_RATE_METER_CORE_MACROS_SVH
`define SLIDING_WINDOW_RATE_METER_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk_i, off during reset
`define SWRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SWRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWRM_ASSERT_IMP(lbl, ante, cons, msg)

`define SWRM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/swrm_pkg.sv
// shared types and constants of the sliding window rate meter
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned ELAPSED_W    = 16;
  localparam int unsigned BYTES_W      = 24;
  localparam int unsigned WINDOW_W     = 16;
  localparam int unsigned TIME_TOT_W   = 22;
  localparam int unsigned BYTES_TOT_W  = 30;
  localparam int unsigned RATE_W       = 38;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;

  localparam int unsigned RING_DEPTH_DEF    = 64;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_MEASURE    = 2'd0,
    OP_START      = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_e;

  typedef struct packed {
    logic [ELAPSED_W-1:0] time_ms;
    logic [BYTES_W-1:0]   bytes;
  } sample_t;

endpackage

`default_nettype wire

FILE: design/swrm_if.sv
// valid/ready channel interfaces for operation beats and result beats
`timescale 1ns / 1ps
`default_nettype none

interface swrm_in_if;
  import swrm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [BYTES_W-1:0]   byte_count;

  modport source (output valid, output operation, output elapsed_ms, output byte_count,
                  input ready);
  modport sink (input valid, input operation, input elapsed_ms, input byte_count,
                output ready);
endinterface

interface swrm_out_if;
  import swrm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RATE_W-1:0]      rate_q8;
  logic [BYTES_TOT_W-1:0] window_bytes;
  logic [TIME_TOT_W-1:0]  window_time_ms;
  logic                   truncated;

  modport source (output valid, output rate_q8, output window_bytes,
                  output window_time_ms, output truncated, input ready);
  modport sink (input valid, input rate_q8, input window_bytes,
                input window_time_ms, input truncated, output ready);
endinterface

`default_nettype wire

FILE: design/swrm_ring.sv
// sample ring memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module swrm_ring #(
  parameter int unsigned DEPTH = swrm_pkg::RING_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [IDX_W-1:0]   wr_addr_i,
  input  wire swrm_pkg::sample_t  wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [IDX_W-1:0]   rd_addr_i,
  output swrm_pkg::sample_t       rd_data_o
);
  import swrm_pkg::*;

  sample_t mem_q [DEPTH];
  sample_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/swrm_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module swrm_div #(
  parameter int unsigned NUM_W = 38,
  parameter int unsigned DEN_W = swrm_pkg::TIME_TOT_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);
  import swrm_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // shift in the next dividend bit and try the subtraction
  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

`default_nettype wire

FILE: design/sliding_window_rate_meter_core.sv
// top level of the sliding window rate meter: control sequencer, totals and result register
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_rate_meter_core_macros.svh"

// Sliding window throughput meter. One beat on in_i is one operation: start arms the
// meter, invalidate disarms it and empties the ring and totals, an armed measure with
// nonzero elapsed_ms appends an (elapsed_ms, byte_count) sample, evicts the oldest
// samples while the time total is above window_ms, and then, if the time total is not
// zero, returns one beat on out_o with the rate in bytes per ms (FRACTION_BITS
// fraction bits, truncated) and both totals. An unarmed measure only arms the meter.
// Samples live in a RING_DEPTH-entry synchronous ring memory; a measure on a full ring
// evicts the oldest first and flags truncated. Items are taken one at a time. In a
// measure, each eviction is a ring read plus a subtract, the full-ring read overlaps
// the accepting cycle, and the restoring divider yields one quotient bit per cycle.
// A result waits for a busy output register, and a finished result waits in the
// output register while the next operation is taken. The user must write window_ms
// through cfg_we_i/cfg_wdata_i only while idle; the block itself does not enforce it.
module sliding_window_rate_meter_core #(
  parameter int unsigned RING_DEPTH    = swrm_pkg::RING_DEPTH_DEF,
  parameter int unsigned FRACTION_BITS = swrm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swrm_pkg::WINDOW_W-1:0] cfg_wdata_i,
  swrm_in_if.sink                            in_i,
  swrm_out_if.source                         out_o
);
  import swrm_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned NUM_W = BYTES_TOT_W + FRACTION_BITS;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_FULL_SUB = 7'b0000010,
    S_STORE    = 7'b0000100,
    S_EV_CHK   = 7'b0001000,
    S_EV_SUB   = 7'b0010000,
    S_DIV      = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic                   armed_q, armed_d;
  logic [IDX_W-1:0]       oldest_q, oldest_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TIME_TOT_W-1:0]  time_q, time_d;
  logic [BYTES_TOT_W-1:0] bytes_q, bytes_d;
  logic [WINDOW_W-1:0]    window_q;
  logic                   trunc_q, trunc_d;
  sample_t                sample_q;

  logic                   out_valid_q, out_valid_d;
  logic [RATE_W-1:0]      out_rate_q;
  logic [BYTES_TOT_W-1:0] out_bytes_q;
  logic [TIME_TOT_W-1:0]  out_time_q;
  logic                   out_trunc_q;
  logic                   load_out;

  logic                   in_acc;
  logic                   ring_full;
  logic                   take_sample;
  logic                   evict;
  logic [IDX_W-1:0]       oldest_nx;
  logic [SUM_W-1:0]       slot_sum;
  logic [IDX_W-1:0]       slot;

  logic                   rd_en;
  logic                   wr_en;
  sample_t                rd_data;

  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       div_num;
  logic [NUM_W-1:0]       div_quot;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ring_full  = (count_q == CNT_W'(RING_DEPTH));

  // a measure that really stores a sample
  assign take_sample = in_acc && (in_i.operation == OP_MEASURE) && armed_q &&
                       (in_i.elapsed_ms != '0);

  // keep evicting while the window is overrun and samples remain
  assign evict = (time_q > TIME_TOT_W'(window_q)) && (count_q != '0);

  assign oldest_nx = (oldest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);

  // write slot is oldest + count folded once into the ring
  assign slot_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
  assign slot     = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                    IDX_W'(slot_sum - SUM_W'(RING_DEPTH)) : IDX_W'(slot_sum);

  // ring reads always target the oldest sample, consumed in the next state
  assign rd_en = (take_sample && ring_full) || ((state_q == S_EV_CHK) && evict);
  assign wr_en = (state_q == S_STORE);

  assign div_num   = NUM_W'(bytes_q) << FRACTION_BITS;
  assign div_start = (state_q == S_EV_CHK) && !evict && (time_q != '0);

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    armed_d  = armed_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    time_d   = time_q;
    bytes_d  = bytes_q;
    trunc_d  = trunc_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.operation)
            OP_START: begin
              armed_d = 1'b1;
            end
            OP_INVALIDATE: begin
              armed_d  = 1'b0;
              oldest_d = '0;
              count_d  = '0;
              time_d   = '0;
              bytes_d  = '0;
            end
            OP_MEASURE: begin
              if (!armed_q) begin
                armed_d = 1'b1;
              end else if (take_sample) begin
                trunc_d = ring_full;
                state_d = ring_full ? S_FULL_SUB : S_STORE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FULL_SUB: begin
        // ring full: retire the oldest before storing
        time_d   = time_q - TIME_TOT_W'(rd_data.time_ms);
        bytes_d  = bytes_q - BYTES_TOT_W'(rd_data.bytes);
        oldest_d = oldest_nx;
        count_d  = count_q - CNT_W'(1);
        state_d  = S_STORE;
      end
      S_STORE: begin
        time_d  = time_q + TIME_TOT_W'(sample_q.time_ms);
        bytes_d = bytes_q + BYTES_TOT_W'(sample_q.bytes);
        count_d = count_q + CNT_W'(1);
        state_d = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (evict) begin
          state_d = S_EV_SUB;
        end else if (time_q != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EV_SUB: begin
        time_d   = time_q - TIME_TOT_W'(rd_data.time_ms);
        bytes_d  = bytes_q - BYTES_TOT_W'(rd_data.bytes);
        oldest_d = oldest_nx;
        count_d  = count_q - CNT_W'(1);
        state_d  = S_EV_CHK;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register holds a result until the sink takes the beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      oldest_q    <= '0;
      count_q     <= '0;
      time_q      <= '0;
      bytes_q     <= '0;
      trunc_q     <= 1'b0;
      window_q    <= WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      time_q      <= time_d;
      bytes_q     <= bytes_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      sample_q.time_ms <= in_i.elapsed_ms;
      sample_q.bytes   <= in_i.byte_count;
    end
    if (load_out) begin
      out_rate_q  <= RATE_W'(div_quot);
      out_bytes_q <= bytes_q;
      out_time_q  <= time_q;
      out_trunc_q <= trunc_q;
    end
  end

  swrm_ring #(
    .DEPTH (RING_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_data_i (sample_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (oldest_q),
    .rd_data_o (rd_data)
  );

  swrm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_TOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (time_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.rate_q8        = out_rate_q;
  assign out_o.window_bytes   = out_bytes_q;
  assign out_o.window_time_ms = out_time_q;
  assign out_o.truncated      = out_trunc_q;

  // sample count never runs past the ring
  `SWRM_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(RING_DEPTH), "sample count over ring depth")

  // a loaded result always has time inside the window and nonzero
  `SWRM_ASSERT_IMP(a_result_in_window, load_out, (time_q != '0) && (time_q <= TIME_TOT_W'(window_q)), "result time outside window")

  // invalidate empties the ring and totals
  `SWRM_ASSERT_NXT(a_invalidate_clears, in_acc && (in_i.operation == OP_INVALIDATE), (count_q == '0) && (time_q == '0) && (bytes_q == '0) && !armed_q, "invalidate left state behind")

  // the divider finishes only while the sequencer waits on it
  `SWRM_ASSERT_IMP(a_div_done_state, div_done, state_q == S_DIV, "divider done outside divide state")

endmodule

`default_nettype wire

FILE: verif/sliding_window_rate_meter_core_test.sv
// self-checking test of the rate meter core: directed and random operations against a model
`timescale 1ns / 1ps
module sliding_window_rate_meter_core_test;
  import swrm_pkg::*;

  localparam int unsigned DEPTH          = RING_DEPTH_DEF;
  localparam int unsigned FRAC           = FRACTION_BITS_DEF;
  // code three is not decoded by the block, it must be dropped silently
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  // covers any leftover work of the longest measure, evictions and divide included
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned PHASES         = 9;

  // elapsed time profiles used by the random phases
  localparam int EL_TINY   = 0;
  localparam int EL_SMALL  = 1;
  localparam int EL_MEDIUM = 2;
  localparam int EL_FULL   = 3;
  localparam int EL_MIXED  = 4;

  typedef struct packed {
    logic [RATE_W-1:0]      rate_q8;
    logic [BYTES_TOT_W-1:0] window_bytes;
    logic [TIME_TOT_W-1:0]  window_time_ms;
    logic                   truncated;
  } rate_beat_t;

  // behavioral copy of the meter plus the queue of rate beats still owed by the block
  class rate_scoreboard;
    logic [WINDOW_W-1:0]    window_ms;
    bit                     armed;
    logic [ELAPSED_W-1:0]   ring_ms [DEPTH];
    logic [BYTES_W-1:0]     ring_bytes [DEPTH];
    int unsigned            head;
    int unsigned            fill;
    logic [TIME_TOT_W-1:0]  time_sum;
    logic [BYTES_TOT_W-1:0] byte_sum;
    rate_beat_t             owed_rates[$];
    int unsigned            mismatches;
    int unsigned            beats_checked;
    int unsigned            truncated_beats;

    function new();
      window_ms       = WINDOW_RESET;
      armed           = 1'b0;
      mismatches      = 0;
      beats_checked   = 0;
      truncated_beats = 0;
      clear_window();
    endfunction

    function void clear_window();
      head     = 0;
      fill     = 0;
      time_sum = '0;
      byte_sum = '0;
    endfunction

    function void evict_oldest();
      time_sum -= TIME_TOT_W'(ring_ms[head]);
      byte_sum -= BYTES_TOT_W'(ring_bytes[head]);
      head      = (head + 1) % DEPTH;
      fill--;
    endfunction

    function int unsigned outstanding();
      return owed_rates.size();
    endfunction

    // apply one accepted operation beat and queue the rate beat it owes, if any
    function void note_operation(logic [OP_W-1:0] op, logic [ELAPSED_W-1:0] el,
                                 logic [BYTES_W-1:0] bc);
      int unsigned       slot;
      bit                trunc;
      logic [RATE_W-1:0] dividend;
      rate_beat_t        beat;
      case (op)
        OP_START: begin
          armed = 1'b1;
        end
        OP_INVALIDATE: begin
          armed = 1'b0;
          clear_window();
        end
        OP_MEASURE: begin
          if (!armed) begin
            armed = 1'b1;
          end else if (el != '0) begin
            trunc = 1'b0;
            if (fill >= DEPTH) begin
              evict_oldest();
              trunc = 1'b1;
            end
            slot             = (head + fill) % DEPTH;
            ring_ms[slot]    = el;
            ring_bytes[slot] = bc;
            fill++;
            time_sum += TIME_TOT_W'(el);
            byte_sum += BYTES_TOT_W'(bc);
            while (time_sum > window_ms && fill > 0) evict_oldest();
            if (time_sum != '0) begin
              dividend            = RATE_W'(byte_sum) << FRAC;
              beat.rate_q8        = dividend / RATE_W'(time_sum);
              beat.window_bytes   = byte_sum;
              beat.window_time_ms = time_sum;
              beat.truncated      = trunc;
              owed_rates.push_back(beat);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_rate(rate_beat_t got);
      rate_beat_t want;
      beats_checked++;
      if (owed_rates.size() == 0) begin
        report_mismatch($sformatf("rate beat with none owed: rate=%0d bytes=%0d ms=%0d",
                                  got.rate_q8, got.window_bytes, got.window_time_ms));
        return;
      end
      want = owed_rates.pop_front();
      if (got.truncated === 1'b1) truncated_beats++;
      if (got.rate_q8 !== want.rate_q8)
        report_mismatch($sformatf("rate_q8 got %0d want %0d", got.rate_q8, want.rate_q8));
      if (got.window_bytes !== want.window_bytes)
        report_mismatch($sformatf("window_bytes got %0d want %0d",
                                  got.window_bytes, want.window_bytes));
      if (got.window_time_ms !== want.window_time_ms)
        report_mismatch($sformatf("window_time_ms got %0d want %0d",
                                  got.window_time_ms, want.window_time_ms));
      if (got.truncated !== want.truncated)
        report_mismatch($sformatf("truncated got %0b want %0b", got.truncated, want.truncated));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [WINDOW_W-1:0] cfg_wdata;

  swrm_in_if  in_bus ();
  swrm_out_if out_bus ();

  rate_scoreboard meter_model = new();

  // idling knobs, set per phase by the stimulus process
  bit          send_idle;
  bit          recv_idle;
  // one-shot request for the long receiver hold-off
  bit          hold_request;
  int unsigned ops_sent;
  int unsigned windows_written;

  sliding_window_rate_meter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one operation beat after a random gap if send_idle, note it in the model once taken
  task automatic send_op(logic [OP_W-1:0] op, logic [ELAPSED_W-1:0] el,
                         logic [BYTES_W-1:0] bc);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.elapsed_ms <= el;
    in_bus.byte_count <= bc;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    meter_model.note_operation(op, el, bc);
    if (op != OP_UNUSED) ops_sent++;
  endtask

  // stop offering, wait for every owed rate beat, then let any resultless eviction finish
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (meter_model.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // window register is only touched while the meter is idle
  task automatic set_window(logic [WINDOW_W-1:0] w);
    drain_and_settle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    meter_model.window_ms = w;
    windows_written++;
  endtask

  function automatic logic [ELAPSED_W-1:0] draw_elapsed(int profile);
    logic [ELAPSED_W-1:0] el;
    case (profile)
      EL_TINY:   el = ELAPSED_W'($urandom_range(0, 3));
      EL_SMALL:  el = ELAPSED_W'($urandom_range(1, 60));
      EL_MEDIUM: el = ELAPSED_W'($urandom_range(1, 2500));
      EL_FULL:   el = ELAPSED_W'($urandom);
      default: begin
        case ($urandom_range(0, 9))
          0:       el = '0;
          1, 2:    el = ELAPSED_W'($urandom);
          default: el = ELAPSED_W'($urandom_range(1, 800));
        endcase
      end
    endcase
    return el;
  endfunction

  function automatic logic [BYTES_W-1:0] draw_bytes();
    logic [BYTES_W-1:0] bc;
    case ($urandom_range(0, 9))
      0:       bc = '0;
      1:       bc = '1;
      default: bc = BYTES_W'($urandom);
    endcase
    return bc;
  endfunction

  // result side: random stalls per beat if recv_idle, plus one long hold-off on request
  initial begin
    rate_beat_t got;
    int unsigned stall;
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        // long hold-off so the output register and the sequencer both fill up
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stall = recv_idle ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      got.rate_q8        = out_bus.rate_q8;
      got.window_bytes   = out_bus.window_bytes;
      got.window_time_ms = out_bus.window_time_ms;
      got.truncated      = out_bus.truncated;
      meter_model.check_rate(got);
    end
  end

  // watchdog: too long without any beat on either channel means the block hung
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("sliding_window_rate_meter_core_test failed");
    $finish;
  end

  initial begin
    int unsigned     phase;
    int unsigned     phase_start;
    int unsigned     quota;
    int unsigned     inv_pct;
    int unsigned     pick;
    int              profile;
    logic [OP_W-1:0] op;
    logic [WINDOW_W-1:0] w;

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = WINDOW_RESET;
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_MEASURE;
    in_bus.elapsed_ms = '0;
    in_bus.byte_count = '0;
    send_idle         = 1'b1;
    recv_idle         = 1'b1;
    hold_request      = 1'b0;
    ops_sent          = 0;
    windows_written   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, window at its reset value of 2000 ms
    send_op(OP_MEASURE, 16'd10, 24'd100);          // unarmed measure only arms
    send_op(OP_MEASURE, 16'd0, 24'd77);            // zero elapsed changes nothing
    send_op(OP_MEASURE, 16'd1, 24'd0);             // first real sample, zero bytes
    send_op(OP_MEASURE, 16'hFFFF, 24'hFFFFFF);     // longer than the window, all evicted
    send_op(OP_MEASURE, 16'd2000, 24'hFFFFFF);     // fills the window exactly
    send_op(OP_MEASURE, 16'd1, 24'd1);             // pushes the big sample out
    send_op(OP_START, 16'd5, 24'd5);               // start while armed keeps the ring
    send_op(OP_MEASURE, 16'd500, 24'd12345);
    send_op(OP_UNUSED, 16'hFFFF, 24'hFFFFFF);      // undecoded code, ignored
    send_op(OP_INVALIDATE, 16'd0, 24'd0);          // disarm and clear
    send_op(OP_MEASURE, 16'd3, 24'd3);             // re-arms only
    send_op(OP_MEASURE, 16'h5555, 24'hAAAAAA);     // alternating bit patterns
    send_op(OP_MEASURE, 16'hAAAA, 24'h555555);
    send_op(OP_MEASURE, 16'd1999, 24'hFFFFFF);
    send_op(OP_MEASURE, 16'd1, 24'hFFFFFF);
    // zero window evicts everything, no beat
    set_window(16'd0);
    send_op(OP_MEASURE, 16'd1, 24'd5);
    send_op(OP_MEASURE, 16'hFFFF, 24'hFFFFFF);
    // widest window
    set_window(16'hFFFF);
    send_op(OP_MEASURE, 16'hFFFF, 24'hFFFFFF);
    send_op(OP_MEASURE, 16'd1, 24'd0);
    // one millisecond window
    set_window(16'd1);
    send_op(OP_MEASURE, 16'd1, 24'hFFFFFF);

    // random part: each phase writes a window, arms, then streams mostly measures
    quota = RANDOM_ITEMS / PHASES;
    for (phase = 0; phase < PHASES; phase++) begin
      send_idle = 1'b1;
      recv_idle = 1'b1;
      case (phase)
        0: begin w = 16'hFFFF; profile = EL_SMALL; inv_pct = 0; end    // ring fills and wraps
        1: begin w = 16'd0; profile = EL_MIXED; inv_pct = 3; end
        2: begin w = 16'd1; profile = EL_TINY; inv_pct = 2; end
        3: begin w = WINDOW_W'($urandom); profile = EL_FULL; inv_pct = 2; end
        4: begin
          // sender keeps pushing while the receiver is held off
          w = WINDOW_RESET; profile = EL_MEDIUM; inv_pct = 1; send_idle = 1'b0;
        end
        5: begin
          // back-to-back stretch, no idling on either side
          w = 16'hFFFF; profile = EL_SMALL; inv_pct = 0;
          send_idle = 1'b0; recv_idle = 1'b0;
        end
        6: begin
          w = WINDOW_W'($urandom_range(100, 5000)); profile = EL_MIXED; inv_pct = 3;
        end
        7: begin w = 16'hFFFF; profile = EL_MEDIUM; inv_pct = 1; end
        default: begin w = WINDOW_RESET; profile = EL_MIXED; inv_pct = 3; end
      endcase
      set_window(w);
      send_op(OP_START, draw_elapsed(EL_FULL), draw_bytes());
      if (phase == 4) hold_request = 1'b1;
      phase_start = ops_sent;
      while (ops_sent - phase_start < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < inv_pct)
          op = OP_INVALIDATE;
        else if (pick < inv_pct + 4)
          op = OP_START;
        else if (pick < inv_pct + 6)
          op = OP_UNUSED;
        else
          op = OP_MEASURE;
        send_op(op, draw_elapsed(profile), draw_bytes());
      end
    end

    drain_and_settle();
    $display("ran %0d operations over %0d window settings, incl. zero and full-scale windows",
             ops_sent, windows_written);
    $display("checked %0d rate beats, %0d of them after a full ring dropped a sample",
             meter_model.beats_checked, meter_model.truncated_beats);
    if (meter_model.mismatches == 0) begin
      $display("sliding_window_rate_meter_core_test passed");
    end else begin
      $display("sliding_window_rate_meter_core_test failed");
    end
    $finish;
  end

endmodule
